// File: hdl/tev_pkg.sv
// types, constants and coordinate mapping shared by the touch event qualifier
package tev_pkg;

    // panel and display geometry
    localparam int PANEL_WIDTH   = 450;
    localparam int PANEL_HEIGHT  = 600;
    localparam int SCREEN_WIDTH  = 600;
    localparam int SCREEN_HEIGHT = 450;

    localparam logic [15:0] PANEL_W_M1   = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] PANEL_H_M1   = 16'(PANEL_HEIGHT - 1);
    localparam logic [15:0] DISPLAY_W_M1 = 16'(SCREEN_WIDTH - 1);
    localparam logic [15:0] DISPLAY_H_M1 = 16'(SCREEN_HEIGHT - 1);

    // failure and release thresholds
    localparam logic [2:0] FAIL_LIMIT      = 3'd5;
    localparam logic [2:0] FAIL_CNT_MAX    = 3'd7;
    localparam logic [1:0] RELEASE_CONFIRM = 2'd2;
    localparam logic [1:0] EMPTY_CNT_MAX   = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam logic [2:0]  REG_POLL_INTERVAL  = 3'd0;
    localparam logic [2:0]  REG_FAIL_BACKOFF   = 3'd1;
    localparam logic [2:0]  REG_RECOVERY_RETRY = 3'd2;
    localparam logic [2:0]  REG_IGNORE_INIT    = 3'd3;
    localparam logic [2:0]  REG_ORIENTATION    = 3'd4;

    // orientation codes
    localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT_FLIP  = 2'd1;
    localparam logic [1:0] ORIENT_LANDSCAPE      = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;

    // event phase codes
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_MOVE  = 2'd1;
    localparam logic [1:0] PHASE_END   = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] RST_POLL_INTERVAL  = 16'd10;
    localparam logic [15:0] RST_FAIL_BACKOFF   = 16'd50;
    localparam logic [15:0] RST_RECOVERY_RETRY = 16'd1000;
    localparam logic [15:0] RST_IGNORE_INIT    = 16'd0;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        gate_idle;
        logic        read_ok;
        logic        decode_ok;
        logic        touched;
        logic [15:0] phys_x;
        logic [15:0] phys_y;
        logic        probe_ok;
    } t_in_beat;

    typedef struct packed {
        logic        event_valid;
        logic        touch_held;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
        logic [1:0]  phase;
        logic        ready_res;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] poll_interval_ms;
        logic [15:0] failure_backoff_ms;
        logic [15:0] recovery_retry_ms;
        logic [15:0] ignore_after_init_ms;
        logic [1:0]  orientation;
    } t_cfg;

    typedef struct packed {
        logic        initialized;
        logic [31:0] last_poll_time;
        logic [31:0] backoff_until;
        logic [31:0] ignore_until;
        logic [2:0]  read_failures;
        logic [1:0]  empty_count;
        logic        active;
        logic [15:0] last_x;
        logic [15:0] last_y;
    } t_track;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } t_xy;

    function automatic logic [15:0] clamp_to(input logic [15:0] v, input logic [15:0] top);
        return (v < top) ? v : top;
    endfunction

    function automatic t_xy map_xy(input logic [1:0] orient, input logic [15:0] px,
                                   input logic [15:0] py);
        t_xy         r;
        logic [15:0] fx;
        logic [15:0] fy;
        fx = PANEL_W_M1 - px;
        fy = PANEL_H_M1 - py;
        case (orient)
            ORIENT_PORTRAIT: begin
                r.x = px;
                r.y = py;
            end
            ORIENT_PORTRAIT_FLIP: begin
                r.x = fx;
                r.y = fy;
            end
            ORIENT_LANDSCAPE: begin
                r.x = clamp_to(fy, DISPLAY_W_M1);
                r.y = clamp_to(px, DISPLAY_H_M1);
            end
            ORIENT_LANDSCAPE_FLIP: begin
                r.x = clamp_to(py, DISPLAY_W_M1);
                r.y = clamp_to(fx, DISPLAY_H_M1);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/tev_step.sv
// next-state and result logic for one poll attempt
module tev_step (
    input  tev_pkg::t_cfg      i_cfg,
    input  tev_pkg::t_track    i_state,
    input  tev_pkg::t_in_beat  i_beat,
    output tev_pkg::t_track    o_state,
    output tev_pkg::t_out_beat o_res
);
    import tev_pkg::*;

    logic [31:0] sum_fail;
    logic [31:0] sum_retry;
    logic [31:0] sum_ignore;
    logic [31:0] since_poll;
    logic        due_backoff;
    logic        due_poll;
    logic [2:0]  fail_inc;
    logic [1:0]  empty_inc;
    logic        release_done;
    t_xy         mapped;

    assign sum_fail     = i_beat.now_ms + 32'(i_cfg.failure_backoff_ms);
    assign sum_retry    = i_beat.now_ms + 32'(i_cfg.recovery_retry_ms);
    assign sum_ignore   = i_beat.now_ms + 32'(i_cfg.ignore_after_init_ms);
    assign since_poll   = i_beat.now_ms - i_state.last_poll_time;
    assign due_backoff  = i_beat.now_ms >= i_state.backoff_until;
    assign due_poll     = since_poll >= 32'(i_cfg.poll_interval_ms);
    assign fail_inc     = (i_state.read_failures < FAIL_CNT_MAX) ?
                          i_state.read_failures + 3'd1 : i_state.read_failures;
    assign empty_inc    = (i_state.empty_count < EMPTY_CNT_MAX) ?
                          i_state.empty_count + 2'd1 : i_state.empty_count;
    assign release_done = empty_inc >= RELEASE_CONFIRM;
    assign mapped       = map_xy(i_cfg.orientation, i_beat.phys_x, i_beat.phys_y);

    always_comb begin
        logic do_release;
        do_release = 1'b0;
        o_state    = i_state;
        o_res      = '0;

        if (!i_state.initialized) begin
            // recovery attempt
            if (due_backoff) begin
                o_state             = '0;
                o_state.initialized = i_beat.probe_ok;
                if (i_beat.probe_ok) begin
                    if (i_cfg.ignore_after_init_ms != '0) begin
                        o_state.ignore_until = sum_ignore;
                    end
                end else begin
                    o_state.backoff_until = sum_retry;
                end
            end
        end else if (due_backoff && due_poll) begin
            o_state.last_poll_time = i_beat.now_ms;
            if (i_beat.gate_idle) begin
                do_release = 1'b1;
            end else if (!i_beat.read_ok) begin
                o_state.backoff_until = sum_fail;
                o_state.read_failures = fail_inc;
                if (fail_inc >= FAIL_LIMIT) begin
                    o_state.initialized   = 1'b0;
                    o_state.active        = 1'b0;
                    o_state.empty_count   = '0;
                    o_state.backoff_until = sum_retry;
                end
            end else begin
                o_state.read_failures = '0;
                if (!i_beat.decode_ok) begin
                    o_state.backoff_until = sum_fail;
                end else if (!i_beat.touched) begin
                    do_release = 1'b1;
                end else if (i_beat.now_ms < i_state.ignore_until) begin
                    o_state.active      = 1'b0;
                    o_state.empty_count = '0;
                end else begin
                    o_state.backoff_until = '0;
                    o_state.empty_count   = '0;
                    o_state.active        = 1'b1;
                    o_state.last_x        = mapped.x;
                    o_state.last_y        = mapped.y;
                    o_res.event_valid     = 1'b1;
                    o_res.touch_held      = 1'b1;
                    o_res.touch_x         = mapped.x;
                    o_res.touch_y         = mapped.y;
                    o_res.phase           = i_state.active ? PHASE_MOVE : PHASE_START;
                end
            end
        end

        // empty sample while a touch is held
        if (do_release && i_state.active) begin
            if (release_done) begin
                o_state.active      = 1'b0;
                o_state.empty_count = '0;
                o_res.event_valid   = 1'b1;
                o_res.touch_held    = 1'b0;
                o_res.touch_x       = i_state.last_x;
                o_res.touch_y       = i_state.last_y;
                o_res.phase         = PHASE_END;
            end else begin
                o_state.empty_count = empty_inc;
            end
        end

        o_res.ready_res = o_state.initialized;
    end

endmodule

// File: hdl/touch_event_qualifier.sv
// touch event qualifier top level: registers, handshakes and configuration
//
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_stall    i_in  (t_in_beat)
//  out       source     o_out_valid / i_out_stall  o_out (t_out_beat)
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  a beat accepted into the input register has its result written into the
//  result register when it advances, and leaves from there; one beat per
//  cycle is sustained while the result side does not stall, the tracking
//  state being updated by a single combinational pass between the input and result registers
//  reset is synchronous and active low; it clears tracking state and loads
//  the configuration defaults
//  a stalled result holds; the input register still takes one more beat
//  behind it, after which o_in_stall rises
//  configuration writes are always taken (o_cfg_ready stays high)
module touch_event_qualifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tev_pkg::t_in_beat             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tev_pkg::t_out_beat            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import tev_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_beat  r_in;
    // result register
    logic      r_out_valid;
    t_out_beat r_out;
    // configuration and tracking state
    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_track    r_state;
    t_track    n_state;

    t_track    step_state;
    t_out_beat step_res;
    logic      in_accept;
    logic      advance;
    logic      cfg_write;

    tev_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_beat  (r_in),
        .o_state (step_state),
        .o_res   (step_res)
    );

    // the held beat moves on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // register writes; a changed orientation clears the tracking state but for initialized and the last coordinates
    always_comb begin
        n_cfg   = r_cfg;
        n_state = advance ? step_state : r_state;
        if (cfg_write) begin
            case (i_cfg_index)
                REG_POLL_INTERVAL:  n_cfg.poll_interval_ms     = i_cfg_data;
                REG_FAIL_BACKOFF:   n_cfg.failure_backoff_ms   = i_cfg_data;
                REG_RECOVERY_RETRY: n_cfg.recovery_retry_ms    = i_cfg_data;
                REG_IGNORE_INIT:    n_cfg.ignore_after_init_ms = i_cfg_data;
                REG_ORIENTATION: begin
                    if (i_cfg_data[1:0] != r_cfg.orientation) begin
                        n_cfg.orientation      = i_cfg_data[1:0];
                        n_state.active         = 1'b0;
                        n_state.last_poll_time = '0;
                        n_state.backoff_until  = '0;
                        n_state.ignore_until   = '0;
                        n_state.read_failures  = '0;
                        n_state.empty_count    = '0;
                    end
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid                 <= 1'b0;
            r_out_valid                <= 1'b0;
            r_state                    <= '0;
            r_cfg.poll_interval_ms     <= RST_POLL_INTERVAL;
            r_cfg.failure_backoff_ms   <= RST_FAIL_BACKOFF;
            r_cfg.recovery_retry_ms    <= RST_RECOVERY_RETRY;
            r_cfg.ignore_after_init_ms <= RST_IGNORE_INIT;
            r_cfg.orientation          <= ORIENT_PORTRAIT;
        end else begin
            r_cfg   <= n_cfg;
            r_state <= n_state;
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

endmodule

// File: hdl/tev_checker.sv
// port-level checks for the touch event qualifier, bound to the top level
module tev_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tev_pkg::t_out_beat o_out
);
    import tev_pkg::*;

    // a beat without an event carries zero fields apart from ready_res
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.event_valid) |->
        (!o_out.touch_held && o_out.touch_x == '0 && o_out.touch_y == '0 &&
         o_out.phase == PHASE_START))
        else $error("event-free beat carries nonzero fields");

    // held flag follows the phase
    a_held_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.event_valid) |->
        (o_out.touch_held == (o_out.phase != PHASE_END)))
        else $error("touch_held disagrees with phase");

    // events come only from a ready controller
    a_event_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.event_valid) |-> o_out.ready_res)
        else $error("event while controller not ready");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed");

endmodule

bind touch_event_qualifier tev_checker u_tev_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// File: bench/tev_event_checker.sv
`timescale 1ns / 100ps
// watches the poll, event and register channels of the qualifier and checks every event beat
module tev_event_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  tev_pkg::t_in_beat             i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  tev_pkg::t_out_beat            i_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [tev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import tev_pkg::*;

    t_cfg      regs;
    t_track    trk;
    t_out_beat expected_events_q[$];
    int        fails = 0;

    task automatic flag(input string what);
        fails++;
        if (fails <= 10) $display("mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) flag($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // one more empty poll while a touch is held; ends it once confirmed
    task automatic confirm_release(inout t_out_beat r);
        if (trk.active) begin
            if (trk.empty_count != EMPTY_CNT_MAX) trk.empty_count++;
            if (trk.empty_count >= RELEASE_CONFIRM) begin
                trk.active      = 1'b0;
                trk.empty_count = '0;
                r.event_valid   = 1'b1;
                r.touch_held    = 1'b0;
                r.touch_x       = trk.last_x;
                r.touch_y       = trk.last_y;
                r.phase         = PHASE_END;
            end
        end
    endtask

    task automatic qualify_poll(input t_in_beat b, output t_out_beat r);
        logic [31:0] since_last;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] mx;
        logic [15:0] my;
        r          = '0;
        since_last = b.now_ms - trk.last_poll_time;
        if (!trk.initialized) begin
            if (b.now_ms >= trk.backoff_until) begin
                // recovery attempt wipes all tracking
                trk             = '0;
                trk.initialized = b.probe_ok;
                if (b.probe_ok) begin
                    if (regs.ignore_after_init_ms != 16'd0)
                        trk.ignore_until = b.now_ms + {16'd0, regs.ignore_after_init_ms};
                end else begin
                    trk.backoff_until = b.now_ms + {16'd0, regs.recovery_retry_ms};
                end
            end
        end else if (b.now_ms >= trk.backoff_until &&
                     since_last >= {16'd0, regs.poll_interval_ms}) begin
            trk.last_poll_time = b.now_ms;
            if (b.gate_idle) begin
                confirm_release(r);
            end else if (!b.read_ok) begin
                trk.backoff_until = b.now_ms + {16'd0, regs.failure_backoff_ms};
                if (trk.read_failures != FAIL_CNT_MAX) trk.read_failures++;
                if (trk.read_failures >= FAIL_LIMIT) begin
                    trk.initialized   = 1'b0;
                    trk.active        = 1'b0;
                    trk.empty_count   = '0;
                    trk.backoff_until = b.now_ms + {16'd0, regs.recovery_retry_ms};
                end
            end else begin
                trk.read_failures = '0;
                if (!b.decode_ok) begin
                    trk.backoff_until = b.now_ms + {16'd0, regs.failure_backoff_ms};
                end else if (!b.touched) begin
                    confirm_release(r);
                end else if (b.now_ms < trk.ignore_until) begin
                    trk.active      = 1'b0;
                    trk.empty_count = '0;
                end else begin
                    fx = PANEL_W_M1 - b.phys_x;
                    fy = PANEL_H_M1 - b.phys_y;
                    case (regs.orientation)
                        ORIENT_PORTRAIT: begin
                            mx = b.phys_x;
                            my = b.phys_y;
                        end
                        ORIENT_PORTRAIT_FLIP: begin
                            mx = fx;
                            my = fy;
                        end
                        ORIENT_LANDSCAPE: begin
                            mx = (fy < DISPLAY_W_M1) ? fy : DISPLAY_W_M1;
                            my = (b.phys_x < DISPLAY_H_M1) ? b.phys_x : DISPLAY_H_M1;
                        end
                        default: begin
                            mx = (b.phys_y < DISPLAY_W_M1) ? b.phys_y : DISPLAY_W_M1;
                            my = (fx < DISPLAY_H_M1) ? fx : DISPLAY_H_M1;
                        end
                    endcase
                    trk.backoff_until = '0;
                    trk.empty_count   = '0;
                    r.event_valid     = 1'b1;
                    r.touch_held      = 1'b1;
                    r.touch_x         = mx;
                    r.touch_y         = my;
                    r.phase           = trk.active ? PHASE_MOVE : PHASE_START;
                    trk.active        = 1'b1;
                    trk.last_x        = mx;
                    trk.last_y        = my;
                end
            end
        end
        r.ready_res = trk.initialized;
    endtask

    always @(posedge i_clk) begin
        t_out_beat predicted;
        t_out_beat oldest;
        if (!i_rst_n) begin
            regs.poll_interval_ms     = RST_POLL_INTERVAL;
            regs.failure_backoff_ms   = RST_FAIL_BACKOFF;
            regs.recovery_retry_ms    = RST_RECOVERY_RETRY;
            regs.ignore_after_init_ms = RST_IGNORE_INIT;
            regs.orientation          = ORIENT_PORTRAIT;
            trk                       = '0;
            expected_events_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_POLL_INTERVAL:  regs.poll_interval_ms     = i_cfg_data;
                    REG_FAIL_BACKOFF:   regs.failure_backoff_ms   = i_cfg_data;
                    REG_RECOVERY_RETRY: regs.recovery_retry_ms    = i_cfg_data;
                    REG_IGNORE_INIT:    regs.ignore_after_init_ms = i_cfg_data;
                    REG_ORIENTATION: begin
                        // only a real change of orientation drops tracking
                        if (i_cfg_data[1:0] != regs.orientation) begin
                            regs.orientation   = i_cfg_data[1:0];
                            trk.active         = 1'b0;
                            trk.last_poll_time = '0;
                            trk.backoff_until  = '0;
                            trk.ignore_until   = '0;
                            trk.read_failures  = '0;
                            trk.empty_count    = '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_events_q.size() == 0) begin
                    flag("event beat with no poll outstanding");
                end else begin
                    oldest = expected_events_q.pop_front();
                    check_field("event_valid", 32'(oldest.event_valid),
                                32'(i_out.event_valid));
                    check_field("touch_held", 32'(oldest.touch_held), 32'(i_out.touch_held));
                    check_field("touch_x", 32'(oldest.touch_x), 32'(i_out.touch_x));
                    check_field("touch_y", 32'(oldest.touch_y), 32'(i_out.touch_y));
                    check_field("phase", 32'(oldest.phase), 32'(i_out.phase));
                    check_field("ready_res", 32'(oldest.ready_res), 32'(i_out.ready_res));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                qualify_poll(i_in, predicted);
                expected_events_q.push_back(predicted);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_events_q.size();
    end

endmodule

// File: bench/tb_touch_event_qualifier.sv
`timescale 1ns / 100ps
// stimulus and verdict for the touch event qualifier, with the event checker beside it
module tb_touch_event_qualifier;
    import tev_pkg::*;

    // generous bound on the whole run
    localparam int unsigned WATCHDOG_NS = 5_000_000;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 poll_valid  = 1'b0;
    logic                 poll_stall;
    t_in_beat             poll_beat   = '0;
    logic                 event_valid;
    logic                 event_stall = 1'b0;
    t_out_beat            event_beat;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [15:0]          cfg_data    = '0;
    int                   fail_count;
    int                   pending_count;

    // random gaps on the poll side and random stalls on the event side
    bit          gaps_on      = 1'b1;
    // running millisecond time that well-formed polls follow
    logic [31:0] clock_ms     = '0;
    // register values the stimulus currently assumes, for spacing the polls
    int unsigned cur_interval = 32'(RST_POLL_INTERVAL);
    int unsigned cur_backoff  = 32'(RST_FAIL_BACKOFF);
    int unsigned cur_retry    = 32'(RST_RECOVERY_RETRY);
    logic [1:0]  cur_orient   = ORIENT_PORTRAIT;
    int unsigned polls_sent   = 0;

    touch_event_qualifier u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (poll_valid),
        .o_in_stall  (poll_stall),
        .i_in        (poll_beat),
        .o_out_valid (event_valid),
        .i_out_stall (event_stall),
        .o_out       (event_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tev_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (poll_valid),
        .i_in_stall   (poll_stall),
        .i_in         (poll_beat),
        .i_out_valid  (event_valid),
        .i_out_stall  (event_stall),
        .i_out        (event_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // event side: stall about 29 percent of the time while gaps are enabled
    always @(posedge clk) begin
        event_stall <= gaps_on && ($urandom_range(99) < 29);
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // move the running time forward and hand back the new value
    function automatic logic [31:0] advance(input int unsigned span_ms);
        clock_ms = clock_ms + span_ms;
        return clock_ms;
    endfunction

    // spacing that clears the poll interval
    function automatic int unsigned normal_step();
        return cur_interval + $urandom_range(3);
    endfunction

    // spacing that clears both the failure backoff and the poll interval
    function automatic int unsigned backoff_step();
        return ((cur_backoff > cur_interval) ? cur_backoff : cur_interval) + $urandom_range(3);
    endfunction

    // mostly on the panel, sometimes at the edges or anywhere in 16 bits
    function automatic logic [15:0] pick_coord(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return 16'($urandom_range(span - 1));
        if (r < 85) return 16'd0;
        if (r < 90) return 16'(span - 1);
        return 16'($urandom());
    endfunction

    // present one poll beat, idling first at random, and wait for it to be taken
    task automatic send_poll(input t_in_beat b);
        while (gaps_on && $urandom_range(99) < 29) begin
            poll_valid <= 1'b0;
            @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll_beat  <= b;
        @(posedge clk);
        while (poll_stall) @(posedge clk);
        polls_sent++;
    endtask

    task automatic poll_at(input logic [31:0] now, input logic idle_gate, input logic rd,
                           input logic dec, input logic tch, input logic [15:0] px,
                           input logic [15:0] py, input logic probe);
        t_in_beat b;
        b.now_ms    = now;
        b.gate_idle = idle_gate;
        b.read_ok   = rd;
        b.decode_ok = dec;
        b.touched   = tch;
        b.phys_x    = px;
        b.phys_y    = py;
        b.probe_ok  = probe;
        send_poll(b);
    endtask

    // fully random content, loosely spaced
    task automatic noise_poll();
        poll_at(advance($urandom_range(cur_interval + 2)), coin(), coin(), coin(), coin(),
                16'($urandom()), 16'($urandom()), coin());
    endtask

    // drop valid and let every outstanding event drain before touching registers
    task automatic settle();
        poll_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write beat; valid stays up across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] interval, input logic [15:0] backoff,
                                 input logic [15:0] retry, input logic [15:0] ignore_ms,
                                 input logic [1:0] orient);
        write_reg(REG_POLL_INTERVAL, interval);
        write_reg(REG_FAIL_BACKOFF, backoff);
        write_reg(REG_RECOVERY_RETRY, retry);
        write_reg(REG_IGNORE_INIT, ignore_ms);
        // upper data bits are junk, only the low two carry the orientation
        write_reg(REG_ORIENTATION, {14'($urandom()), orient});
        // writes past the last register must change nothing
        write_reg(REG_ORIENTATION + 3'($urandom_range(1, 3)), 16'($urandom()));
        cfg_valid    <= 1'b0;
        cur_interval  = 32'(interval);
        cur_backoff   = 32'(backoff);
        cur_retry     = 32'(retry);
        cur_orient    = orient;
    endtask

    // mostly touch gestures with random coordinates, plus failures and noise
    task automatic run_random(input int unsigned count);
        int unsigned goal;
        int unsigned pick;
        int unsigned n;
        goal = polls_sent + count;
        while (polls_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // press, a few moves, then empty polls; one empty poll alone is a glitch
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(99) < 12) noise_poll();
                    poll_at(advance(normal_step()), 1'b0, 1'b1, 1'b1, 1'b1,
                            pick_coord(PANEL_WIDTH), pick_coord(PANEL_HEIGHT),
                            $urandom_range(9) != 0);
                end
                n = $urandom_range(1, 3);
                repeat (n) begin
                    if (coin())
                        poll_at(advance(normal_step()), 1'b1, coin(), coin(), coin(),
                                16'($urandom()), 16'($urandom()), $urandom_range(9) != 0);
                    else
                        poll_at(advance(normal_step()), 1'b0, 1'b1, 1'b1, 1'b0,
                                16'($urandom()), 16'($urandom()), $urandom_range(9) != 0);
                end
            end else if (pick < 70) begin
                // read failures in a row; five of them force a recovery
                n = $urandom_range(1, 6);
                repeat (n) begin
                    poll_at(advance(backoff_step()), 1'b0, 1'b0, coin(), coin(),
                            16'($urandom()), 16'($urandom()), coin());
                end
                poll_at(advance(cur_retry + $urandom_range(3)), coin(), coin(), coin(), coin(),
                        pick_coord(PANEL_WIDTH), pick_coord(PANEL_HEIGHT),
                        $urandom_range(3) != 0);
                poll_at(advance(cur_retry + $urandom_range(3)), coin(), 1'b1, 1'b1, coin(),
                        pick_coord(PANEL_WIDTH), pick_coord(PANEL_HEIGHT), 1'b1);
            end else if (pick < 80) begin
                // undecodable packet, then a poll once the backoff has run out
                poll_at(advance(normal_step()), 1'b0, 1'b1, 1'b0, coin(),
                        16'($urandom()), 16'($urandom()), coin());
                poll_at(advance(backoff_step()), 1'b0, 1'b1, 1'b1, 1'b1,
                        pick_coord(PANEL_WIDTH), pick_coord(PANEL_HEIGHT), 1'b1);
            end else if (pick < 90) begin
                noise_poll();
            end else if (pick < 95) begin
                // stray time value off the running clock, every bit random
                poll_at($urandom(), coin(), coin(), coin(), coin(),
                        16'($urandom()), 16'($urandom()), 1'b1);
            end else begin
                // too soon after the last poll, mostly rate limited
                poll_at(advance($urandom_range(cur_interval)), 1'b0, 1'b1, 1'b1, 1'b1,
                        pick_coord(PANEL_WIDTH), pick_coord(PANEL_HEIGHT), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk with reset register values, portrait
        poll_at(32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 16'd5, 16'd5, 1'b0);       // probe fails
        poll_at(32'd999, 1'b0, 1'b1, 1'b1, 1'b1, 16'd5, 16'd5, 1'b1);     // retry not over
        poll_at(32'd1000, 1'b0, 1'b1, 1'b1, 1'b1, 16'd5, 16'd5, 1'b1);    // recovered
        poll_at(32'd1010, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // start at origin
        poll_at(32'd1015, 1'b0, 1'b1, 1'b1, 1'b1, 16'd7, 16'd7, 1'b1);    // rate limited
        poll_at(32'd1020, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        poll_at(32'd1030, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);    // gate idle
        poll_at(32'd1040, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0);    // release ends
        poll_at(32'd1050, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // idle, no touch
        poll_at(32'd1060, 1'b0, 1'b1, 1'b1, 1'b1, 16'd449, 16'd599, 1'b1);
        poll_at(32'd1070, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // one empty only
        poll_at(32'd1080, 1'b0, 1'b1, 1'b1, 1'b1, 16'd100, 16'd200, 1'b1); // still a move
        poll_at(32'd1090, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1);    // decode fails
        poll_at(32'd1100, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1, 16'd1, 1'b1);    // in backoff
        poll_at(32'd1140, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // read failures
        poll_at(32'd1190, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1);
        poll_at(32'd1240, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1);
        poll_at(32'd1290, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1);
        poll_at(32'd1340, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // fifth, recovery
        poll_at(32'd1400, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // retry pending
        poll_at(32'd2340, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);    // recovered again
        poll_at(32'd2350, 1'b0, 1'b1, 1'b1, 1'b1, 16'd300, 16'd400, 1'b1); // fresh start
        poll_at(32'd2360, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1);
        poll_at(32'd2370, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1);    // end
        clock_ms = 32'd2370;

        // every register change happens with the pipe empty
        settle();
        load_settings(16'd10, 16'd50, 16'd1000, 16'd0, ORIENT_PORTRAIT_FLIP);
        run_random(240);

        // all pauses zero, and a long stretch with no gaps or stalls
        settle();
        gaps_on = 1'b0;
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, ORIENT_LANDSCAPE);
        run_random(240);

        // all pauses at their maximum
        settle();
        gaps_on = 1'b1;
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ORIENT_LANDSCAPE_FLIP);
        run_random(150);

        // short retry with a window of ignored touches after each recovery
        settle();
        load_settings(16'd5, 16'd20, 16'd200, 16'd100, ORIENT_PORTRAIT);
        run_random(260);

        // running time crosses the 32-bit wrap
        settle();
        clock_ms = 32'hFFFF_FC00;
        load_settings(16'd10, 16'd50, 16'd1000, 16'd0, cur_orient + 2'd1);
        run_random(200);

        // random settings, orientation always changing
        for (int p = 0; p < 3; p++) begin
            settle();
            load_settings(16'($urandom_range(20)), 16'($urandom_range(100)),
                          16'($urandom_range(1500)), 16'($urandom_range(300)),
                          cur_orient + 2'($urandom_range(1, 3)));
            run_random(220);
        end

        // same orientation written again: tracking must survive
        settle();
        load_settings(16'($urandom_range(20)), 16'($urandom_range(100)),
                      16'($urandom_range(1500)), 16'($urandom_range(300)), cur_orient);
        run_random(180);

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // a stuck handshake ends the run here
    initial begin
        #(WATCHDOG_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/tev_pkg.sv
hdl/tev_step.sv
hdl/touch_event_qualifier.sv
hdl/tev_checker.sv
bench/tev_event_checker.sv
bench/tb_touch_event_qualifier.sv
